// ===== src/pfbf_pkg.sv =====
// Shared types, codes and defaults for the partition table block.
package pfbf_pkg;

  // Default sizing of the table.
  localparam int MAX_PARTS_DEF   = 64;
  localparam int OFFSET_BITS_DEF = 16;

  // Fixed field widths.
  localparam int SIZE_W   = 16;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 2;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  // Result status codes.
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t STAT_OK       = 2'd0;
  localparam status_t STAT_NO_FIT   = 2'd1;
  localparam status_t STAT_FULL     = 2'd2;
  localparam status_t STAT_BAD_SLOT = 2'd3;

  // Operation codes of an input item.
  localparam logic OP_SEARCH = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // Gap selection modes.
  localparam logic FIT_FIRST = 1'b0;
  localparam logic FIT_BEST  = 1'b1;

  // Register indexes, taken from paddr[3:2].
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_FIT_MODE = 2'd0;
  localparam reg_idx_t REG_MEM_SIZE = 2'd1;
  localparam reg_idx_t REG_BASE     = 2'd2;

  // Register reset values.
  localparam logic [SIZE_W-1:0] MEM_SIZE_RST = 16'd4096;
  localparam logic [ADDR_W-1:0] BASE_RST     = 32'd0;

endpackage

// ===== src/partition_first_best_fit_table_core.sv =====
// Partition table with first-fit and best-fit gap search and insert at a given slot.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   operation, request_size, start_address,
//                                             part_length, slot_in
//   out_     output     out_valid / out_stall status, gap_address, slot_out, part_count
//   cfg      APB        psel/penable/pwrite   fit_mode @0, memory_size @4, base_address @8
//
// A search measures one gap per cycle through a single subtract-and-compare unit fed by the
// table memory's registered read port, stopping early when first fit hits, and then loads
// the result register.
// An insert moves m = count - slot_in + 1 entries one place higher, each read through the
// registered read port and written back, then writes the new entry and loads the result
// register; full-table and bad-slot inserts go straight to the result state.
// Synchronous active-low reset; the table memory is not cleared, only the count.
// in_stall is high from acceptance until the result is loaded; the result register
// holds its item while out_stall is high.
module partition_first_best_fit_table_core #(
  parameter int MAX_PARTS   = pfbf_pkg::MAX_PARTS_DEF,
  parameter int OFFSET_BITS = pfbf_pkg::OFFSET_BITS_DEF,
  localparam int SLOT_W     = $clog2(MAX_PARTS + 2)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_operation,
  input  logic [pfbf_pkg::SIZE_W-1:0]  in_request_size,
  input  logic [pfbf_pkg::ADDR_W-1:0]  in_start_address,
  input  logic [pfbf_pkg::SIZE_W-1:0]  in_part_length,
  input  logic [SLOT_W-1:0]            in_slot_in,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output pfbf_pkg::status_t            out_status,
  output logic [pfbf_pkg::ADDR_W-1:0]  out_gap_address,
  output logic [SLOT_W-1:0]            out_slot_out,
  output logic [SLOT_W-1:0]            out_part_count,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pfbf_pkg::APB_AW-1:0]  paddr,
  input  logic [pfbf_pkg::APB_DW-1:0]  pwdata,
  output logic [pfbf_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import pfbf_pkg::*;

  localparam int AW    = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int CNT_W = $clog2(MAX_PARTS + 1);
  localparam int GW    = ((OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W) + 1;
  localparam int MW    = 2 * OFFSET_BITS;

  typedef enum logic [1:0] {S_IDLE, S_SRCH, S_INS, S_DONE} state_t;

  state_t                 state_r, state_nxt;
  logic                   fit_mode_r, fit_mode_nxt;
  logic [SIZE_W-1:0]      mem_size_r, mem_size_nxt;
  logic [ADDR_W-1:0]      base_r, base_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [SIZE_W-1:0]      req_r, req_nxt;
  logic [SIZE_W-1:0]      len_r, len_nxt;
  logic [OFFSET_BITS-1:0] ins_s_r, ins_s_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]       scan_r, scan_nxt;
  logic [SLOT_W-1:0]      gi_r, gi_nxt;
  logic                   pend_r, pend_nxt;
  logic [OFFSET_BITS-1:0] prev_end_r, prev_end_nxt;
  logic                   found_r, found_nxt;
  logic [GW-1:0]          best_r, best_nxt;
  logic [OFFSET_BITS-1:0] best_left_r, best_left_nxt;
  logic [SLOT_W-1:0]      best_slot_r, best_slot_nxt;
  status_t                res_status_r, res_status_nxt;
  logic [AW-1:0]          wa_r, wa_nxt;
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]      out_gap_r, out_gap_nxt;
  logic [SLOT_W-1:0]      out_slot_r, out_slot_nxt;
  logic [SLOT_W-1:0]      out_count_r, out_count_nxt;

  // Table memory: start offset in the upper half, end offset in the lower half.
  logic [MW-1:0]          mem [MAX_PARTS];
  logic [MW-1:0]          rd_data_r;
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic [AW-1:0]          mem_ra;
  logic [MW-1:0]          mem_wd;

  logic [OFFSET_BITS-1:0] rd_start;
  logic [OFFSET_BITS-1:0] rd_end;
  logic [GW-1:0]          right_w;
  logic [GW-1:0]          gap_w;
  logic                   cfg_we;
  logic                   eval;
  logic                   last;
  logic                   fit;
  logic                   better;

  assign rd_start = rd_data_r[MW-1:OFFSET_BITS];
  assign rd_end   = rd_data_r[OFFSET_BITS-1:0];
  assign cfg_we   = psel & penable & pwrite;
  assign pready   = 1'b1;

  // Shared gap unit: right neighbor's start (or the memory size after the last entry) minus left neighbor's end.
  assign right_w = pend_r ? GW'(rd_start) : GW'(mem_size_r);
  assign gap_w   = right_w - GW'(prev_end_r);

  // Register read-back.
  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_FIT_MODE: prdata = APB_DW'(fit_mode_r);
      REG_MEM_SIZE: prdata = APB_DW'(mem_size_r);
      REG_BASE:     prdata = APB_DW'(base_r);
      default:      prdata = '0;
    endcase
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt      = state_r;
    fit_mode_nxt   = fit_mode_r;
    mem_size_nxt   = mem_size_r;
    base_nxt       = base_r;
    count_nxt      = count_r;
    req_nxt        = req_r;
    len_nxt        = len_r;
    ins_s_nxt      = ins_s_r;
    idx_nxt        = idx_r;
    scan_nxt       = scan_r;
    gi_nxt         = gi_r;
    pend_nxt       = pend_r;
    prev_end_nxt   = prev_end_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_left_nxt  = best_left_r;
    best_slot_nxt  = best_slot_r;
    res_status_nxt = res_status_r;
    wa_nxt         = wa_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_status_nxt = out_status_r;
    out_gap_nxt    = out_gap_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_wa         = wa_r;
    mem_wd         = rd_data_r;
    mem_ra         = scan_r[AW-1:0];
    eval           = 1'b0;
    last           = 1'b0;
    fit            = 1'b0;
    better         = 1'b0;

    // The user must issue configuration writes only while the block is idle; the block itself does not enforce this.
    if (cfg_we) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_FIT_MODE: fit_mode_nxt = pwdata[0];
        REG_MEM_SIZE: mem_size_nxt = pwdata[SIZE_W-1:0];
        REG_BASE:     base_nxt     = pwdata[ADDR_W-1:0];
        default:      ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt       = in_request_size;
          len_nxt       = in_part_length;
          ins_s_nxt     = OFFSET_BITS'(in_start_address - base_r);
          scan_nxt      = '0;
          gi_nxt        = '0;
          pend_nxt      = 1'b0;
          prev_end_nxt  = '0;
          found_nxt     = 1'b0;
          best_nxt      = '0;
          best_left_nxt = '0;
          best_slot_nxt = '0;
          if (in_operation == OP_SEARCH) begin
            state_nxt = S_SRCH;
          end else if (count_r == CNT_W'(MAX_PARTS)) begin
            res_status_nxt = STAT_FULL;
            state_nxt      = S_DONE;
          end else if (in_slot_in == '0 ||
                       in_slot_in > SLOT_W'(count_r) + SLOT_W'(1)) begin
            res_status_nxt = STAT_BAD_SLOT;
            state_nxt      = S_DONE;
          end else begin
            idx_nxt        = CNT_W'(in_slot_in - SLOT_W'(1));
            scan_nxt       = count_r;
            best_slot_nxt  = in_slot_in;
            res_status_nxt = STAT_OK;
            state_nxt      = S_INS;
          end
        end
      end

      S_SRCH: begin
        // Fetch the next entry while the previous one is measured.
        if (scan_r < count_r) begin
          mem_ra   = scan_r[AW-1:0];
          scan_nxt = scan_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        last = !pend_r && (scan_r >= count_r);
        eval = pend_r || last;
        if (eval) begin
          fit    = $signed(gap_w) >= $signed(GW'(req_r));
          better = !found_r || ($signed(gap_w) < $signed(best_r));
          if (fit && (fit_mode_r == FIT_FIRST || better)) begin
            found_nxt     = 1'b1;
            best_nxt      = gap_w;
            best_left_nxt = prev_end_r;
            best_slot_nxt = gi_r + SLOT_W'(1);
          end
          if (pend_r) begin
            prev_end_nxt = rd_end;
          end
          gi_nxt = gi_r + SLOT_W'(1);
          if ((fit && fit_mode_r == FIT_FIRST) || last) begin
            res_status_nxt = found_nxt ? STAT_OK : STAT_NO_FIT;
            state_nxt      = S_DONE;
          end
        end
      end

      S_INS: begin
        // Write back the entry read last cycle one place higher.
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wa = wa_r;
          mem_wd = rd_data_r;
        end
        if (scan_r > idx_r) begin
          mem_ra   = AW'(scan_r - CNT_W'(1));
          wa_nxt   = scan_r[AW-1:0];
          scan_nxt = scan_r - CNT_W'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            mem_we    = 1'b1;
            mem_wa    = idx_r[AW-1:0];
            mem_wd    = {ins_s_r, ins_s_r + OFFSET_BITS'(len_r)};
            count_nxt = count_r + CNT_W'(1);
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        // Load the result register once it is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_gap_nxt    = found_r ? base_r + ADDR_W'(best_left_r) : '0;
          out_slot_nxt   = best_slot_r;
          out_count_nxt  = SLOT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State, registers and result outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fit_mode_r  <= FIT_FIRST;
      mem_size_r  <= MEM_SIZE_RST;
      base_r      <= BASE_RST;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fit_mode_r  <= fit_mode_nxt;
      mem_size_r  <= mem_size_nxt;
      base_r      <= base_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    len_r        <= len_nxt;
    ins_s_r      <= ins_s_nxt;
    idx_r        <= idx_nxt;
    scan_r       <= scan_nxt;
    gi_r         <= gi_nxt;
    prev_end_r   <= prev_end_nxt;
    found_r      <= found_nxt;
    best_r       <= best_nxt;
    best_left_r  <= best_left_nxt;
    best_slot_r  <= best_slot_nxt;
    res_status_r <= res_status_nxt;
    wa_r         <= wa_nxt;
    out_status_r <= out_status_nxt;
    out_gap_r    <= out_gap_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Table memory with one write port and a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_gap_address = out_gap_r;
  assign out_slot_out    = out_slot_r;
  assign out_part_count  = out_count_r;

endmodule

// ===== src/pfbf_chk.sv =====
// Port-level checks for the partition table block, bound to its top level.
module pfbf_chk #(
  parameter int MAX_PARTS = pfbf_pkg::MAX_PARTS_DEF,
  localparam int SLOT_W   = $clog2(MAX_PARTS + 2)
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input pfbf_pkg::status_t           out_status,
  input logic [pfbf_pkg::ADDR_W-1:0] out_gap_address,
  input logic [SLOT_W-1:0]           out_slot_out,
  input logic [SLOT_W-1:0]           out_part_count
);
  import pfbf_pkg::*;

  // A stalled result item stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_gap_address) && $stable(out_slot_out) && $stable(out_part_count))
    else $error("result item changed while stalled");

  // Any failing item reports no gap and no slot.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_gap_address == '0 && out_slot_out == '0)
    else $error("failing item carries an address or slot");

  // A successful item always names a slot after the leading sentinel.
  a_ok_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_OK |-> out_slot_out != '0)
    else $error("successful item with slot zero");

  // A full-table refusal only happens with the table at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_FULL |-> out_part_count == SLOT_W'(MAX_PARTS))
    else $error("table full reported below capacity");

  // The partition count never passes the table size.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_part_count <= SLOT_W'(MAX_PARTS))
    else $error("partition count above table size");

endmodule

bind partition_first_best_fit_table_core pfbf_chk #(.MAX_PARTS(MAX_PARTS)) u_pfbf_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_gap_address (out_gap_address),
  .out_slot_out    (out_slot_out),
  .out_part_count  (out_part_count)
);
